@@ sv/update_job_phase_controller_unit_assert.svh @@
// Assertion helpers for the update job phase controller.
// Each check is sampled on clk and held off while rst_n is low.
`ifndef UPDATE_JOB_PHASE_CONTROLLER_UNIT_ASSERT_SVH
`define UPDATE_JOB_PHASE_CONTROLLER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UJPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UJPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ujpc_pkg.sv @@
`timescale 1ns / 1ps

package ujpc_pkg;

    localparam int SIZE_W  = 25;
    localparam int JOB_W   = 32;
    localparam int TIME_W  = 48;
    localparam int TMO_W   = 32;
    localparam int DL_W    = TIME_W + 1;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] MIN_IMAGE = SIZE_W'(8192);
    // 4 KiB alignment: low 12 bits of the size must be zero
    localparam int ALIGN_BITS = 12;

    localparam logic [SIZE_W-1:0] IMAGE_LIMIT_RST    = SIZE_W'(8388608);
    localparam logic [TMO_W-1:0]  JOB_TIMEOUT_RST    = TMO_W'(300000000);
    localparam logic [TMO_W-1:0]  IDLE_TIMEOUT_RST   = TMO_W'(30000000);
    localparam logic [TMO_W-1:0]  STAGED_TIMEOUT_RST = TMO_W'(60000000);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JOB_TIMEOUT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STAGED_TIMEOUT = 2'd3;

    typedef enum logic [2:0] {
        KIND_BEGIN    = 3'd0,
        KIND_WRITE    = 3'd1,
        KIND_VERIFY   = 3'd2,
        KIND_STAGE    = 3'd3,
        KIND_ACTIVATE = 3'd4,
        KIND_CANCEL   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_RECEIVING  = 3'd1,
        PH_VERIFYING  = 3'd2,
        PH_STAGED     = 3'd3,
        PH_ACTIVATING = 3'd4,
        PH_CANCELLED  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SIZE_W-1:0] byte_count;
        logic [JOB_W-1:0]  job_ident;
        logic [TIME_W-1:0] now;
    } cmd_t;

    typedef struct packed {
        logic              accepted;
        logic [2:0]        phase_out;
        logic [JOB_W-1:0]  current_job;
        logic              busy_res;
        logic              expired;
    } result_t;

    typedef struct packed {
        logic [SIZE_W-1:0] image_limit;
        logic [TMO_W-1:0]  job_timeout;
        logic [TMO_W-1:0]  idle_timeout;
        logic [TMO_W-1:0]  staged_timeout;
    } cfg_t;

endpackage

@@ sv/ujpc_if.sv @@
`timescale 1ns / 1ps

interface ujpc_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [24:0] byte_count;
    logic [31:0] job_ident;
    logic [47:0] now;

    modport source (output valid, output kind, output byte_count, output job_ident,
                    output now, input ready);
    modport sink (input valid, input kind, input byte_count, input job_ident,
                  input now, output ready);
endinterface

interface ujpc_res_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  phase_out;
    logic [31:0] current_job;
    logic        busy_res;
    logic        expired;

    modport source (output valid, output accepted, output phase_out, output current_job,
                    output busy_res, output expired, input ready);
    modport sink (input valid, input accepted, input phase_out, input current_job,
                  input busy_res, input expired, output ready);
endinterface

@@ sv/update_job_phase_controller_unit.sv @@
`timescale 1ns / 1ps

// Update job phase controller. Each command word (begin, write, verify, stage,
// activate, cancel, stamped with a 48-bit microsecond time) produces exactly one
// result word: accept flag, phase and job id after the command, busy and expired.
// One command per clock is sustained while the result side keeps ready high. A
// word lands in the input register, is decided and applied to the job state
// when it moves on, together with loading the result register, from which the
// result word is presented. The rate is set by the update of the job state
// registers as each command is decided. While a result waits on a stalled
// output the input register can still take one more word and then holds ready
// low until the result moves on.
// Configuration registers must be written only while no command is in flight.

module update_job_phase_controller_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    ujpc_cmd_if.sink                           cmd,
    ujpc_res_if.source                         res,
    input  logic                               cfg_wr_en,
    input  logic [ujpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ujpc_pkg::CFG_W-1:0]         cfg_data
);
    import ujpc_pkg::*;

    `include "update_job_phase_controller_unit_assert.svh"

    cfg_t    cfg_reg;
    logic    stage_valid;
    cmd_t    stage_word;
    logic    fire;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    expired_ok;
    logic    begin_taken;

    assign fire = stage_valid && (!res_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_limit    <= IMAGE_LIMIT_RST;
            cfg_reg.job_timeout    <= JOB_TIMEOUT_RST;
            cfg_reg.idle_timeout   <= IDLE_TIMEOUT_RST;
            cfg_reg.staged_timeout <= STAGED_TIMEOUT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_IMAGE_LIMIT:    cfg_reg.image_limit    <= cfg_data[SIZE_W-1:0];
                REG_JOB_TIMEOUT:    cfg_reg.job_timeout    <= cfg_data[TMO_W-1:0];
                REG_IDLE_TIMEOUT:   cfg_reg.idle_timeout   <= cfg_data[TMO_W-1:0];
                REG_STAGED_TIMEOUT: cfg_reg.staged_timeout <= cfg_data[TMO_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    ujpc_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .take  (fire),
        .valid (stage_valid),
        .word  (stage_word)
    );

    ujpc_phase_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .cmd      (stage_word),
        .cfg      (cfg_reg),
        .res_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.accepted    = res_reg.accepted;
    assign res.phase_out   = res_reg.phase_out;
    assign res.current_job = res_reg.current_job;
    assign res.busy_res    = res_reg.busy_res;
    assign res.expired     = res_reg.expired;

    // expiry only means something while receiving, verifying or staged
    assign expired_ok  = !res.expired || (res.phase_out == PH_RECEIVING) ||
                         (res.phase_out == PH_VERIFYING) || (res.phase_out == PH_STAGED);
    assign begin_taken = fire && res_next.accepted && (stage_word.kind == KIND_BEGIN);

    `UJPC_ASSERT_SAME(a_expired_phase, res.valid, expired_ok, "expired outside an active phase")
    `UJPC_ASSERT_NEXT(a_fire_result, fire, res.valid, "decided command left no result word")
    `UJPC_ASSERT_NEXT(a_stage_hold, stage_valid && !fire, stage_valid, "held command word dropped")
    `UJPC_ASSERT_NEXT(a_job_nonzero, begin_taken, res.current_job != '0, "begin gave job id zero")

endmodule

@@ sv/ujpc_in_stage.sv @@
`timescale 1ns / 1ps

module ujpc_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    ujpc_cmd_if.sink      cmd,
    input  logic          take,
    output logic          valid,
    output ujpc_pkg::cmd_t word
);
    import ujpc_pkg::*;

    logic valid_reg;
    cmd_t word_reg;

    // slot frees up in the same cycle the held word moves on
    assign cmd.ready = !valid_reg || take;
    assign valid = valid_reg;
    assign word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.valid && cmd.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            word_reg <= '{kind: cmd.kind, byte_count: cmd.byte_count,
                          job_ident: cmd.job_ident, now: cmd.now};
        end
    end

endmodule

@@ sv/ujpc_phase_core.sv @@
`timescale 1ns / 1ps

module ujpc_phase_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  ujpc_pkg::cmd_t     cmd,
    input  ujpc_pkg::cfg_t     cfg,
    output ujpc_pkg::result_t  res_next
);
    import ujpc_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [JOB_W-1:0]  job_reg, job_next;
    logic [SIZE_W-1:0] expected_reg, expected_next;
    logic [SIZE_W-1:0] received_reg, received_next;
    logic [DL_W-1:0]   deadline_reg, deadline_next;
    logic [TIME_W-1:0] progress_reg, progress_next;

    logic              ok;
    logic              expired_after;
    logic              active_old;
    logic              busy_old;
    logic              dl_hit;
    logic              idle_hit;
    logic              expired_old;
    logic              size_fits;
    logic [SIZE_W:0]   recv_sum;
    logic [TIME_W-1:0] since_progress;
    logic [JOB_W-1:0]  job_inc;
    logic              idle_zero;
    logic              ident_match;

    assign active_old = (phase_reg == PH_RECEIVING) || (phase_reg == PH_VERIFYING) ||
                        (phase_reg == PH_STAGED);
    assign busy_old   = active_old || (phase_reg == PH_ACTIVATING);

    assign dl_hit         = {1'b0, cmd.now} >= deadline_reg;
    assign since_progress = cmd.now - progress_reg;
    // time running backwards suspends the idle check
    assign idle_hit       = (cmd.now >= progress_reg) &&
                            (since_progress >= {{(TIME_W-TMO_W){1'b0}}, cfg.idle_timeout});
    assign expired_old    = active_old && (dl_hit || ((phase_reg == PH_RECEIVING) && idle_hit));

    assign size_fits   = (cmd.byte_count >= MIN_IMAGE) && (cmd.byte_count <= cfg.image_limit) &&
                         (cmd.byte_count[ALIGN_BITS-1:0] == '0);
    assign recv_sum    = {1'b0, received_reg} + {1'b0, cmd.byte_count};
    assign job_inc     = job_reg + JOB_W'(1);
    assign idle_zero   = (cfg.idle_timeout == '0);
    assign ident_match = (job_reg == cmd.job_ident);

    // Expiry after the command is worked out from the old compares: a fresh
    // deadline or progress stamp equals now plus a timeout, so it has already
    // passed exactly when that timeout is zero.
    always_comb
    begin
        ok            = 1'b0;
        phase_next    = phase_reg;
        job_next      = job_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        deadline_next = deadline_reg;
        progress_next = progress_reg;
        expired_after = expired_old;
        case (kind_t'(cmd.kind))
            KIND_BEGIN:
            begin
                if (!busy_old && size_fits)
                begin
                    ok            = 1'b1;
                    phase_next    = PH_RECEIVING;
                    job_next      = (job_inc == '0) ? JOB_W'(1) : job_inc;
                    expected_next = cmd.byte_count;
                    received_next = '0;
                    deadline_next = {1'b0, cmd.now} + {{(DL_W-TMO_W){1'b0}}, cfg.job_timeout};
                    progress_next = cmd.now;
                    expired_after = (cfg.job_timeout == '0) || idle_zero;
                end
            end
            KIND_WRITE:
            begin
                if ((phase_reg == PH_RECEIVING) && !expired_old && (cmd.byte_count != '0) &&
                    (recv_sum <= {1'b0, expected_reg}))
                begin
                    ok            = 1'b1;
                    received_next = recv_sum[SIZE_W-1:0];
                    progress_next = cmd.now;
                    expired_after = dl_hit || idle_zero;
                end
            end
            KIND_VERIFY:
            begin
                if ((phase_reg == PH_RECEIVING) && (received_reg == expected_reg) &&
                    !expired_old)
                begin
                    ok            = 1'b1;
                    phase_next    = PH_VERIFYING;
                    expired_after = dl_hit;
                end
            end
            KIND_STAGE:
            begin
                if ((phase_reg == PH_VERIFYING) && !expired_old)
                begin
                    ok            = 1'b1;
                    phase_next    = PH_STAGED;
                    deadline_next = {1'b0, cmd.now} +
                                    {{(DL_W-TMO_W){1'b0}}, cfg.staged_timeout};
                    expired_after = (cfg.staged_timeout == '0);
                end
            end
            KIND_ACTIVATE:
            begin
                if ((phase_reg == PH_STAGED) && ident_match && !expired_old)
                begin
                    ok            = 1'b1;
                    phase_next    = PH_ACTIVATING;
                    expired_after = 1'b0;
                end
            end
            KIND_CANCEL:
            begin
                if (active_old && ident_match)
                begin
                    ok            = 1'b1;
                    phase_next    = PH_CANCELLED;
                    expired_after = 1'b0;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign res_next.accepted    = ok;
    assign res_next.phase_out   = phase_next;
    assign res_next.current_job = job_next;
    assign res_next.busy_res    = (phase_next == PH_RECEIVING) || (phase_next == PH_VERIFYING) ||
                                  (phase_next == PH_STAGED) || (phase_next == PH_ACTIVATING);
    assign res_next.expired     = expired_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            job_reg      <= '0;
            expected_reg <= '0;
            received_reg <= '0;
            deadline_reg <= '0;
            progress_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            job_reg      <= job_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            deadline_reg <= deadline_next;
            progress_reg <= progress_next;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ujpc_pkg::*;

    localparam int          CYCLE_LIMIT = 250000;
    localparam logic [24:0] MIN_BYTES   = 25'd8192;
    localparam logic [24:0] PAGE_MASK   = 25'd4095;
    localparam int unsigned MAX_BYTES   = 16777216;
    // kind codes the block has no command for
    localparam logic [2:0]  KIND_RSVD6  = 3'd6;
    localparam logic [2:0]  KIND_RSVD7  = 3'd7;

    // Tracks the job state the block should hold and the result words still owed.
    class job_scoreboard;
        phase_t      phase;
        logic [31:0] job_id;
        logic [24:0] exp_bytes;
        logic [24:0] rcv_bytes;
        logic [48:0] deadline;
        logic [47:0] last_prog;
        logic [24:0] image_limit;
        logic [31:0] job_tmo;
        logic [31:0] idle_tmo;
        logic [31:0] staged_tmo;
        result_t     expected_q[$];
        int          errors;

        function new();
            phase       = PH_IDLE;
            job_id      = '0;
            exp_bytes   = '0;
            rcv_bytes   = '0;
            deadline    = '0;
            last_prog   = '0;
            image_limit = 25'd8388608;
            job_tmo     = 32'd300000000;
            idle_tmo    = 32'd30000000;
            staged_tmo  = 32'd60000000;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_IMAGE_LIMIT:    image_limit = data[24:0];
                REG_JOB_TIMEOUT:    job_tmo     = data;
                REG_IDLE_TIMEOUT:   idle_tmo    = data;
                REG_STAGED_TIMEOUT: staged_tmo  = data;
                default: ;
            endcase
        endfunction

        function bit busy();
            return phase >= PH_RECEIVING && phase <= PH_ACTIVATING;
        endfunction

        // idle timeout only counts while receiving, and not when time ran backwards
        function bit timed_out(logic [47:0] t);
            if (phase < PH_RECEIVING || phase > PH_STAGED)
                return 1'b0;
            if ({1'b0, t} >= deadline)
                return 1'b1;
            return phase == PH_RECEIVING && t >= last_prog &&
                   (t - last_prog) >= {16'd0, idle_tmo};
        endfunction

        function void note_cmd(cmd_t c);
            result_t r;
            bit      ok;
            ok = 1'b0;
            case (c.kind)
                KIND_BEGIN:
                    if (!busy() && c.byte_count >= MIN_BYTES && c.byte_count <= image_limit &&
                        (c.byte_count & PAGE_MASK) == '0)
                    begin
                        job_id    = (job_id == '1) ? 32'd1 : job_id + 32'd1;
                        phase     = PH_RECEIVING;
                        exp_bytes = c.byte_count;
                        rcv_bytes = '0;
                        deadline  = {1'b0, c.now} + {17'd0, job_tmo};
                        last_prog = c.now;
                        ok        = 1'b1;
                    end
                KIND_WRITE:
                    if (phase == PH_RECEIVING && !timed_out(c.now) && c.byte_count != '0 &&
                        {1'b0, rcv_bytes} + {1'b0, c.byte_count} <= {1'b0, exp_bytes})
                    begin
                        rcv_bytes = rcv_bytes + c.byte_count;
                        last_prog = c.now;
                        ok        = 1'b1;
                    end
                KIND_VERIFY:
                    if (phase == PH_RECEIVING && rcv_bytes == exp_bytes && !timed_out(c.now))
                    begin
                        phase = PH_VERIFYING;
                        ok    = 1'b1;
                    end
                KIND_STAGE:
                    if (phase == PH_VERIFYING && !timed_out(c.now))
                    begin
                        phase    = PH_STAGED;
                        deadline = {1'b0, c.now} + {17'd0, staged_tmo};
                        ok       = 1'b1;
                    end
                KIND_ACTIVATE:
                    if (phase == PH_STAGED && job_id == c.job_ident && !timed_out(c.now))
                    begin
                        phase = PH_ACTIVATING;
                        ok    = 1'b1;
                    end
                KIND_CANCEL:
                    if (busy() && phase != PH_ACTIVATING && job_id == c.job_ident)
                    begin
                        phase = PH_CANCELLED;
                        ok    = 1'b1;
                    end
                default: ;
            endcase
            r.accepted    = ok;
            r.phase_out   = phase;
            r.current_job = job_id;
            r.busy_res    = busy();
            r.expired     = timed_out(c.now);
            expected_q.push_back(r);
        endfunction

        function void cmp(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $error("%s: expected %0h, got %0h", field, exp_v, act_v);
            end
        endfunction

        function void check_res(result_t got);
            result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $error("result word with no command outstanding");
                return;
            end
            e = expected_q.pop_front();
            cmp("accepted", 32'(e.accepted), 32'(got.accepted));
            cmp("phase_out", 32'(e.phase_out), 32'(got.phase_out));
            cmp("current_job", e.current_job, got.current_job);
            cmp("busy_res", 32'(e.busy_res), 32'(got.busy_res));
            cmp("expired", 32'(e.expired), 32'(got.expired));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    ujpc_cmd_if cmd_if ();
    ujpc_res_if res_if ();

    job_scoreboard sb = new();

    int          n_sent    = 0;
    int          cmd_gap   = 0;
    bit          no_gaps   = 1'b0;
    bit          res_burst = 1'b0;
    logic [47:0] now_us    = '0;
    int unsigned step_max  = 1000;
    int          cycle_cnt = 0;

    update_job_phase_controller_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .res       (res_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays high across back-to-back words; it drops when a gap follows or park() is called
    task automatic send(input logic [2:0] kind, input logic [24:0] bytes,
                        input logic [31:0] ident, input logic [47:0] t);
        cmd_t c;
        repeat (cmd_gap) @(posedge clk);
        cmd_if.valid      <= 1'b1;
        cmd_if.kind       <= kind;
        cmd_if.byte_count <= bytes;
        cmd_if.job_ident  <= ident;
        cmd_if.now        <= t;
        do @(posedge clk); while (!cmd_if.ready);
        c.kind       = kind;
        c.byte_count = bytes;
        c.job_ident  = ident;
        c.now        = t;
        sb.note_cmd(c);
        n_sent++;
        cmd_gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (cmd_gap != 0)
            cmd_if.valid <= 1'b0;
    endtask

    task automatic park();
        if (cmd_gap == 0)
            cmd_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_config(input logic [24:0] limit, input logic [31:0] job_t,
                              input logic [31:0] idle_t, input logic [31:0] staged_t);
        park();
        drain();
        write_reg(REG_IMAGE_LIMIT, {7'd0, limit});
        write_reg(REG_JOB_TIMEOUT, job_t);
        write_reg(REG_IDLE_TIMEOUT, idle_t);
        write_reg(REG_STAGED_TIMEOUT, staged_t);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly small forward steps, some long ones that run past timeouts,
    // a few steps back in time and the odd jump anywhere in the 48-bit range
    function automatic logic [47:0] tick();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            now_us = now_us + 48'($urandom_range(0, step_max));
        else if (r < 93)
            now_us = now_us + 48'($urandom_range(step_max, 4 * step_max));
        else if (r < 97)
            now_us = now_us - 48'($urandom_range(1, step_max));
        else
            now_us = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
        return now_us;
    endfunction

    function automatic logic [31:0] wrong_id();
        logic [31:0] v;
        v = $urandom;
        if (v == sb.job_id)
            v = v ^ 32'd1;
        return v;
    endfunction

    function automatic logic [24:0] pick_size();
        int unsigned r;
        int unsigned pages;
        r     = $urandom_range(0, 99);
        pages = 32'(sb.image_limit) >> 12;
        if (r < 55)
            return 25'($urandom_range(2, (pages < 8) ? pages : 8) << 12);
        else if (r < 70)
            return 25'(pages << 12);
        else if (r < 80)
            return 25'($urandom_range(2, pages) << 12);
        else if (r < 85)
            return 25'((((pages + 1) << 12) > MAX_BYTES) ? MAX_BYTES : ((pages + 1) << 12));
        else if (r < 90)
            return 25'(($urandom_range(2, 8) << 12) + $urandom_range(1, 4095));
        else if (r < 95)
            return 25'($urandom_range(0, 8191));
        return 25'($urandom_range(0, MAX_BYTES));
    endfunction

    function automatic logic [24:0] pick_chunk();
        int unsigned r;
        int unsigned rem;
        r   = $urandom_range(0, 99);
        rem = 32'(sb.exp_bytes) - 32'(sb.rcv_bytes);
        if (rem == 0 || r >= 92)
            return 25'($urandom_range(0, MAX_BYTES));
        else if (r < 65)
            return 25'($urandom_range(1, rem));
        else if (r < 80)
            return 25'(rem);
        else if (r < 85)
            return '0;
        return 25'((rem + 1 > MAX_BYTES) ? MAX_BYTES : rem + 1);
    endfunction

    task automatic noise();
        logic [2:0]  k;
        logic [31:0] id;
        k  = 3'($urandom_range(0, 7));
        id = $urandom_range(0, 1) ? sb.job_id : 32'($urandom);
        // a matching activate would lock the block until reset
        if (k == KIND_ACTIVATE)
            id = wrong_id();
        send(k, 25'($urandom_range(0, MAX_BYTES)), id, tick());
    endtask

    // one job from begin to an optional cancel, with random sizes, times and stray words
    task automatic run_job();
        int unsigned r;
        int          n;
        no_gaps = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0)
            noise();
        send(KIND_BEGIN, pick_size(), $urandom, tick());
        n = $urandom_range(0, 6);
        for (int i = 0; i < n && sb.phase == PH_RECEIVING && sb.rcv_bytes != sb.exp_bytes; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                noise();
            send(KIND_WRITE, pick_chunk(), $urandom, tick());
        end
        if (sb.phase == PH_RECEIVING && sb.rcv_bytes != sb.exp_bytes &&
            $urandom_range(0, 9) != 0)
            send(KIND_WRITE, sb.exp_bytes - sb.rcv_bytes, $urandom, tick());
        if ($urandom_range(0, 9) == 0)
            noise();
        if ($urandom_range(0, 19) != 0)
            send(KIND_VERIFY, 25'($urandom_range(0, MAX_BYTES)), $urandom, tick());
        if ($urandom_range(0, 19) != 0)
            send(KIND_STAGE, 25'($urandom_range(0, MAX_BYTES)), $urandom, tick());
        r = $urandom_range(0, 99);
        if (r < 25)
            send(KIND_ACTIVATE, 25'($urandom_range(0, MAX_BYTES)), wrong_id(), tick());
        // sometimes the job is left busy so the next begin is refused
        if (r < 90)
        begin
            if (r >= 80)
                send(KIND_CANCEL, 25'($urandom_range(0, MAX_BYTES)), wrong_id(), tick());
            send(KIND_CANCEL, 25'($urandom_range(0, MAX_BYTES)), sb.job_id, tick());
        end
    endtask

    task automatic run_jobs(input int quota);
        int stop_at;
        stop_at = n_sent + quota;
        while (n_sent < stop_at) run_job();
    endtask

    initial
    begin
        result_t got;
        int      stall;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 40) == 0)
                res_burst = !res_burst;
            stall = res_burst ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            got.accepted    = res_if.accepted;
            got.phase_out   = res_if.phase_out;
            got.current_job = res_if.current_job;
            got.busy_res    = res_if.busy_res;
            got.expired     = res_if.expired;
            sb.check_res(got);
        end
    end

    initial
    begin
        int unsigned idle_t;
        rst_n             <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.kind       <= KIND_BEGIN;
        cmd_if.byte_count <= '0;
        cmd_if.job_ident  <= '0;
        cmd_if.now        <= '0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= REG_IMAGE_LIMIT;
        cfg_data          <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset register values
        send(KIND_CANCEL, 25'd0, 32'd0, 48'd1000);           // idle, id matches the zero job
        send(KIND_WRITE, 25'd4096, 32'd0, 48'd1000);
        send(KIND_BEGIN, 25'd4096, 32'd0, 48'd1001);         // under minimum
        send(KIND_BEGIN, 25'd10240, 32'd0, 48'd1002);        // not page aligned
        send(KIND_BEGIN, 25'd8392704, 32'd0, 48'd1003);      // one page over the limit
        send(KIND_BEGIN, 25'd8388608, 32'd0, 48'd1004);      // exactly the limit
        send(KIND_WRITE, 25'd0, 32'd0, 48'd1005);
        send(KIND_WRITE, 25'd16777216, '1, 48'd1006);        // more than missing
        send(KIND_VERIFY, 25'd0, 32'd0, 48'd1007);           // incomplete
        send(KIND_WRITE, 25'd8388608, 32'd0, 48'd1008);
        send(KIND_VERIFY, 25'd0, 32'd0, 48'd1009);
        send(KIND_STAGE, 25'd0, 32'd0, 48'd1010);
        send(KIND_ACTIVATE, 25'd0, 32'd2, 48'd1011);         // wrong job
        send(KIND_ACTIVATE, 25'd0, 32'd1, 48'd60001010);     // right at the staged deadline
        send(KIND_CANCEL, 25'd0, 32'd1, 48'd60001011);       // cancel ignores expiry
        send(KIND_RSVD6, 25'd8192, 32'd1, 48'd60001012);
        send(KIND_RSVD7, 25'd8192, 32'd1, 48'd60001013);
        // deadline beyond the 48-bit time range, then time going backwards
        send(KIND_BEGIN, 25'd8192, 32'd0, 48'hFFFF_FFFF_FF00);
        send(KIND_WRITE, 25'd4096, 32'd0, 48'hFFFF_FFFF_FE00);
        send(KIND_WRITE, 25'd4096, 32'd0, 48'hFFFF_FFFF_FFFF);
        send(KIND_VERIFY, 25'd0, 32'd0, 48'hFFFF_FFFF_FFFF);
        send(KIND_CANCEL, 25'd0, 32'd2, 48'hFFFF_FFFF_FFFF);
        // no write progress for the whole idle window
        send(KIND_BEGIN, 25'd8192, 32'd0, 48'd5000);
        send(KIND_WRITE, 25'd4096, 32'd0, 48'd30005000);
        send(KIND_CANCEL, 25'd0, 32'd3, 48'd30005001);
        now_us = 48'd30005001;

        set_config(25'd16777216, '1, '1, '1);
        step_max = 1000;
        run_jobs(250);

        // every job is expired from the moment it begins
        set_config(25'd8192, '0, '0, '0);
        step_max = 5;
        run_jobs(60);

        repeat (4)
        begin
            idle_t = $urandom_range(50, 3000);
            set_config(25'($urandom_range(8192, MAX_BYTES)), $urandom_range(500, 20000),
                       idle_t, $urandom_range(50, 5000));
            step_max = idle_t / 4 + 1;
            run_jobs(200);
        end

        set_config(25'($urandom_range(8192, MAX_BYTES)), $urandom, $urandom, $urandom);
        step_max = 1 << 20;
        run_jobs(150);

        // a successful activate locks the block, so it comes last
        set_config(25'd16777216, '1, '1, '1);
        step_max = 100;
        no_gaps  = 1'b0;
        send(KIND_BEGIN, 25'd8192, $urandom, tick());
        send(KIND_WRITE, 25'd8192, $urandom, tick());
        send(KIND_VERIFY, 25'd0, $urandom, tick());
        send(KIND_STAGE, 25'd0, $urandom, tick());
        send(KIND_ACTIVATE, 25'd0, sb.job_id, tick());
        send(KIND_BEGIN, 25'd8192, $urandom, tick());
        send(KIND_WRITE, 25'd4096, $urandom, tick());
        send(KIND_CANCEL, 25'd0, sb.job_id, tick());
        send(KIND_VERIFY, 25'd0, $urandom, tick());
        send(KIND_STAGE, 25'd0, $urandom, tick());
        send(KIND_RSVD7, 25'd0, sb.job_id, tick());

        park();
        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ujpc_pkg.sv
sv/ujpc_if.sv
sv/ujpc_in_stage.sv
sv/ujpc_phase_core.sv
sv/update_job_phase_controller_unit.sv
tb/tb_top.sv
